/* rtl/core/linear_probe_hash_table_core_assert.svh */
// Assertion macros for the linear probe hash table core.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LPHT_ASSERT_NOW(label, ante, cons, msg)
`define LPHT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/lpht_pkg.sv */
// Shared constants, codes and types of the linear probe hash table core.
// No dependencies; every module of the core imports it.
package lpht_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 3;

    // A new key is refused once the table holds three quarters of capacity.
    localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'(3 * CAPACITY / 4);

    // Integer hash constants
    localparam logic [KEY_W-1:0] HASH_MASK = 32'h3fff_ffff;
    localparam int SH_A      = 18;
    localparam int SH_B      = 31;
    localparam int MUL_SH_LO = 2;    // times 21 = 1 + 4 + 16
    localparam int MUL_SH_HI = 4;
    localparam int SH_C      = 11;
    localparam int SH_D      = 6;
    localparam int SH_E      = 22;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [ST_W-1:0] ST_HIT     = 3'd0;
    localparam logic [ST_W-1:0] ST_MISS    = 3'd1;
    localparam logic [ST_W-1:0] ST_NEW     = 3'd2;
    localparam logic [ST_W-1:0] ST_UPDATED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic             act;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wv;
        logic [IDX_W-1:0] idx;
    } t_item;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] entry_count;
    } t_back_stat;

endpackage

/* rtl/core/linear_probe_hash_table_core.sv */
// Linear probe hash table core: 64-slot key/value table, lookups and inserts.
// The key is hashed in two registered stages and queued; the back end then probes
// slots from the hashed index, and a lookup on an empty table skips probing. The back
// end takes a new item only after the last is answered, with the single read port of the key/value memories.
// Reset (synchronous, active low) empties the table and drops queued items;
// the slot memories are not cleared, their used bits are.
`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [lpht_pkg::KEY_W-1:0] i_key,
    input  logic [lpht_pkg::VAL_W-1:0] i_write_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lpht_pkg::ST_W-1:0]  o_status,
    output logic [lpht_pkg::VAL_W-1:0] o_read_value
);
    import lpht_pkg::*;

    // front end to queue
    logic       w_push;
    t_item      w_push_item;
    logic       w_q_full;
    // queue to back end
    logic       w_q_valid;
    t_item      w_q_item;
    logic       w_q_pop;
    t_back_stat w_stat;

    // Hash the key in two stages; hold the input with stall once both stages
    // and the queue are occupied.
    lpht_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_push        (w_push),
        .o_item        (w_push_item),
        .i_q_full      (w_q_full)
    );

    // Decouple hashing from probing so the front keeps taking transfers
    // while the back end walks a long probe chain.
    lpht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Walk slots one per cycle from the hashed index, update the table and
    // park the result in the output register until it is transferred.
    lpht_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_stat       (w_stat)
    );

    // Only a lookup hit carries a value.
    `LPHT_ASSERT_NOW(a_rdval_zero, o_out_valid && (o_status != ST_HIT), o_read_value == '0, "non-zero value without hit")
    // Occupancy never exceeds the load limit.
    `LPHT_ASSERT_NOW(a_count_bound, 1'b1, w_stat.entry_count <= LOAD_LIMIT, "entry count above load limit")
    // Occupancy moves only by one, together with a new-entry result.
    `LPHT_ASSERT_NOW(a_count_step, $past(i_rst_n) && (w_stat.entry_count != $past(w_stat.entry_count)), o_out_valid && (o_status == ST_NEW) && (w_stat.entry_count == $past(w_stat.entry_count) + 1'b1), "entry count changed without new entry")
    // A popped item is either being probed or already answered.
    `LPHT_ASSERT_NEXT(a_pop_busy, w_q_pop, w_stat.busy || o_out_valid, "popped item lost")

endmodule

/* rtl/core/lpht_front.sv */
// Front end: input handshake and two-stage key hash pipeline.
// Depends on lpht_pkg; feeds lpht_queue.
module lpht_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [lpht_pkg::KEY_W-1:0] i_key,
    input  logic [lpht_pkg::VAL_W-1:0] i_write_value,
    output logic                       o_push,
    output lpht_pkg::t_item            o_item,
    input  logic                       i_q_full
);
    import lpht_pkg::*;

    logic             r_v1, r_v2;
    logic             r_act1, r_act2;
    logic [KEY_W-1:0] r_key1, r_key2;
    logic [VAL_W-1:0] r_wv1, r_wv2;
    logic [KEY_W-1:0] r_h1, r_h2;

    logic             en1, en2, accept;
    logic [KEY_W-1:0] h_a, s1_hash, h_m, s2_hash, h_f, h_g, h_masked;

    always_comb begin
        h_a      = ~i_key + (i_key << SH_A);
        s1_hash  = h_a ^ (h_a >> SH_B);
        h_m      = r_h1 + (r_h1 << MUL_SH_LO) + (r_h1 << MUL_SH_HI);
        s2_hash  = h_m ^ (h_m >> SH_C);
        h_f      = r_h2 + (r_h2 << SH_D);
        h_g      = h_f ^ (h_f >> SH_E);
        h_masked = h_g & HASH_MASK;
    end

    // advance a stage when it is empty or its successor moves
    assign en2        = !r_v2 || !i_q_full;
    assign en1        = !r_v1 || en2;
    assign accept     = i_in_valid && en1;
    assign o_in_stall = !en1;
    assign o_push     = r_v2 && !i_q_full;

    assign o_item.act = r_act2;
    assign o_item.key = r_key2;
    assign o_item.wv  = r_wv2;
    assign o_item.idx = h_masked[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act1 <= i_action;
            r_key1 <= i_key;
            r_wv1  <= i_write_value;
            r_h1   <= s1_hash;
        end
        if (en2 && r_v1) begin
            r_act2 <= r_act1;
            r_key2 <= r_key1;
            r_wv2  <= r_wv1;
            r_h2   <= s2_hash;
        end
    end

endmodule

/* rtl/core/lpht_queue.sv */
// Short queue of hashed items between front and back end.
// Depends on lpht_pkg.
module lpht_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpht_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lpht_pkg::t_item o_item
);
    import lpht_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/lpht_back.sv */
// Back end: probe sequencer over the key and value memories, result register.
// Depends on lpht_pkg; fed by lpht_queue.
module lpht_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  lpht_pkg::t_item            i_q_item,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lpht_pkg::ST_W-1:0]  o_status,
    output logic [lpht_pkg::VAL_W-1:0] o_read_value,
    output lpht_pkg::t_back_stat       o_stat
);
    import lpht_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PROBE = 1'b1;
    localparam logic [IDX_W-1:0] PROBE_LAST = IDX_W'(CAPACITY - 1);

    logic [KEY_W-1:0] mem_key [CAPACITY];
    logic [VAL_W-1:0] mem_val [CAPACITY];
    logic [CAPACITY-1:0] r_used;

    logic             r_state, n_state;
    logic             r_act;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_wv;
    logic [IDX_W-1:0] r_idx, r_probes;
    logic             r_used_q;
    logic [KEY_W-1:0] r_rd_key;
    logic [VAL_W-1:0] r_rd_val;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_rdval;

    logic             out_free, match, settle, last;
    logic             start, idx_adv, rd_en, res_load, wr_key, wr_val, set_used;
    logic [IDX_W-1:0] rd_addr;
    logic [ST_W-1:0]  res_status;
    logic [VAL_W-1:0] res_val;

    assign out_free = !r_out_valid || !i_out_stall;
    assign match    = r_used_q && (r_rd_key == r_key);
    assign settle   = !r_used_q || match;
    assign last     = (r_probes == PROBE_LAST);

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        start      = 1'b0;
        idx_adv    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_idx;
        res_load   = 1'b0;
        res_status = ST_MISS;
        res_val    = '0;
        wr_key     = 1'b0;
        wr_val     = 1'b0;
        set_used   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.act == ACT_LOOKUP && r_count == '0) begin
                        // empty table: miss without probing
                        if (out_free) begin
                            o_q_pop  = 1'b1;
                            res_load = 1'b1;
                        end
                    end else begin
                        o_q_pop = 1'b1;
                        start   = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = i_q_item.idx;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (settle || last) begin
                    if (out_free) begin
                        res_load = 1'b1;
                        n_state  = S_IDLE;
                        if (r_act == ACT_LOOKUP) begin
                            if (match) begin
                                res_status = ST_HIT;
                                res_val    = r_rd_val;
                            end
                        end else if (match) begin
                            res_status = ST_UPDATED;
                            wr_val     = 1'b1;
                        end else if (!r_used_q) begin
                            if (r_count >= LOAD_LIMIT) begin
                                res_status = ST_FULL;
                            end else begin
                                res_status = ST_NEW;
                                wr_key     = 1'b1;
                                wr_val     = 1'b1;
                                set_used   = 1'b1;
                            end
                        end else begin
                            // whole table walked without a free slot
                            res_status = ST_FULL;
                        end
                    end
                end else begin
                    idx_adv = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = r_idx + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_used      <= '0;
        end else begin
            r_state <= n_state;
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (set_used) begin
                r_used[r_idx] <= 1'b1;
                r_count       <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_act    <= i_q_item.act;
            r_key    <= i_q_item.key;
            r_wv     <= i_q_item.wv;
            r_idx    <= i_q_item.idx;
            r_probes <= '0;
        end else if (idx_adv) begin
            r_idx    <= r_idx + 1'b1;
            r_probes <= r_probes + 1'b1;
        end
        if (rd_en) begin
            r_used_q <= r_used[rd_addr];
        end
        if (res_load) begin
            r_status <= res_status;
            r_rdval  <= res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_key) begin
            mem_key[r_idx] <= r_key;
        end
        if (wr_val) begin
            mem_val[r_idx] <= r_wv;
        end
        if (rd_en) begin
            r_rd_key <= mem_key[rd_addr];
            r_rd_val <= mem_val[rd_addr];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_read_value       = r_rdval;
    assign o_stat.busy        = (r_state == S_PROBE);
    assign o_stat.entry_count = r_count;

endmodule

/* tb/linear_probe_hash_table_core_tb.sv */
// Self-checking testbench for linear_probe_hash_table_core: lookups and inserts
// against an in-bench model of the 64-slot linearly probed table, random idling.
// Depends on lpht_pkg and the core RTL only.
`timescale 1ns / 100ps

module linear_probe_hash_table_core_tb;
    import lpht_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Drain margin allows for a probe over every slot
    localparam int DRAIN_CYCLES = CAPACITY + 40;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value;
    } t_table_result;

    // Mirror of the table contents; works out the response for each transfer
    // and holds the responses still owed by the core.
    class t_hash_scoreboard;
        bit               used[CAPACITY];
        logic [KEY_W-1:0] keys[CAPACITY];
        logic [VAL_W-1:0] vals[CAPACITY];
        int               entries;
        int               errors;
        t_table_result    owed_results[$];
        logic [KEY_W-1:0] live_keys[$];

        function new();
            foreach (used[i]) used[i] = 1'b0;
            entries = 0;
            errors  = 0;
        endfunction

        // Shift/add/xor integer hash, masked to 30 bits
        function logic [KEY_W-1:0] scramble(input logic [KEY_W-1:0] v);
            logic [KEY_W-1:0] h;
            h = ~v + (v << SH_A);
            h = h ^ (h >> SH_B);
            h = h + (h << MUL_SH_LO) + (h << MUL_SH_HI);
            h = h ^ (h >> SH_C);
            h = h + (h << SH_D);
            h = h ^ (h >> SH_E);
            return h & HASH_MASK;
        endfunction

        function logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
            logic [KEY_W-1:0] h;
            h = scramble(key);
            return h[IDX_W-1:0];
        endfunction

        // Draw random keys until one hashes to the wanted home slot
        function logic [KEY_W-1:0] key_homed_at(input int slot);
            logic [KEY_W-1:0] k;
            k = $urandom;
            while (home_slot(k) != IDX_W'(slot)) k = $urandom;
            return k;
        endfunction

        // Walk from the home slot; settle on a matching key or an unused slot
        function bit find_slot(input logic [KEY_W-1:0] key, output logic [IDX_W-1:0] pos);
            logic [IDX_W-1:0] idx;
            idx = home_slot(key);
            pos = idx;
            for (int n = 0; n < CAPACITY; n++) begin
                if (!used[idx] || keys[idx] == key) begin
                    pos = idx;
                    return 1'b1;
                end
                idx = idx + 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(input logic act, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] wv);
            t_table_result    r;
            logic [IDX_W-1:0] pos;
            bit               found;
            r.status = ST_MISS;
            r.value  = '0;
            if (act == ACT_LOOKUP) begin
                if (entries != 0) begin
                    found = find_slot(key, pos);
                    if (found && used[pos]) begin
                        r.status = ST_HIT;
                        r.value  = vals[pos];
                    end
                end
            end else begin
                found = find_slot(key, pos);
                if (!found) begin
                    r.status = ST_FULL;
                end else if (used[pos]) begin
                    vals[pos] = wv;
                    r.status  = ST_UPDATED;
                end else if (entries >= int'(LOAD_LIMIT)) begin
                    r.status = ST_FULL;
                end else begin
                    used[pos] = 1'b1;
                    keys[pos] = key;
                    vals[pos] = wv;
                    entries++;
                    live_keys.push_back(key);
                    r.status = ST_NEW;
                end
            end
            owed_results.push_back(r);
        endfunction

        task report(input string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(input logic [ST_W-1:0] st, input logic [VAL_W-1:0] v);
            t_table_result want;
            if (owed_results.size() == 0) begin
                report($sformatf("result with none outstanding: status %0d value %08h", st, v));
                return;
            end
            want = owed_results.pop_front();
            if (st !== want.status)
                report($sformatf("status %0d, wanted %0d", st, want.status));
            if (v !== want.value)
                report($sformatf("read_value %08h, wanted %08h", v, want.value));
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_action      = ACT_LOOKUP;
    logic [KEY_W-1:0]   i_key         = '0;
    logic [VAL_W-1:0]   i_write_value = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [ST_W-1:0]    o_status;
    logic [VAL_W-1:0]   o_read_value;

    t_hash_scoreboard sb = new();

    int          burst_left  = 0;
    int          cycle_count = 0;
    logic [9:0]  stall_phase = '0;

    linear_probe_hash_table_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offer one item and hold it until the core takes the transfer. Between
    // bursts of random length, drop valid for a random gap; a zero gap keeps
    // valid high straight across the burst boundary.
    task automatic send_item(input logic act, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] wv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_key         <= key;
        i_write_value <= wv;
        // Values read straight after the edge are the ones the core sampled
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(act, key, wv);
        burst_left--;
    endtask

    // Result side: check every transfer, then pick the next stall value. The
    // pattern changes with the top two bits of the phase counter: no stall, coin
    // flips, stalled three quarters of the time, and long stall runs.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_read_value);
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 1) == 0);
            2'd2: i_out_stall <= (stall_phase[1:0] != 2'd0);
            default: i_out_stall <= (stall_phase[4:3] == 2'b11);
        endcase
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("linear_probe_hash_table_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [KEY_W-1:0] wrap_keys[4];
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wv;
        int               pick;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lookups on the empty table skip probing and miss
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'hffff_ffff);
        send_item(ACT_LOOKUP, 32'hffff_ffff, 32'h0000_0000);
        // Extreme keys and values, then hits on both
        send_item(ACT_INSERT, 32'h0000_0000, 32'hffff_ffff);
        send_item(ACT_INSERT, 32'hffff_ffff, 32'h0000_0000);
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
        // Overwrite an existing key, read it back, miss on a populated table
        send_item(ACT_INSERT, 32'h0000_0000, 32'h5a5a_a5a5);
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_item(ACT_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        // Cluster on the last slot so probes wrap round to slot zero
        foreach (wrap_keys[i]) begin
            wrap_keys[i] = sb.key_homed_at(CAPACITY - 1);
            send_item(ACT_INSERT, wrap_keys[i], $urandom);
        end
        foreach (wrap_keys[i]) send_item(ACT_LOOKUP, wrap_keys[i], '0);
        // Absent key from the same cluster: miss only after the wrapped walk
        send_item(ACT_LOOKUP, sb.key_homed_at(CAPACITY - 1), '0);
        send_item(ACT_INSERT, wrap_keys[3], 32'h8000_0001);
        send_item(ACT_LOOKUP, wrap_keys[3], '0);
        send_item(ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(ACT_LOOKUP, 32'h8000_0000, '0);

        // Random: new keys fill the table to its load limit early on, after
        // which further new keys are refused as full while updates and
        // lookups keep probing the dense clusters.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            wv   = $urandom;
            if (sb.live_keys.size() == 0 || pick < 30) begin
                case ($urandom_range(0, 7))
                    0: key = $urandom_range(0, 255);
                    1: key = sb.key_homed_at($urandom_range(CAPACITY - 4, CAPACITY - 1));
                    default: key = $urandom;
                endcase
                send_item(ACT_INSERT, key, wv);
            end else if (pick < 50) begin
                key = sb.live_keys[$urandom_range(0, sb.live_keys.size() - 1)];
                send_item(ACT_INSERT, key, wv);
            end else if (pick < 82) begin
                key = sb.live_keys[$urandom_range(0, sb.live_keys.size() - 1)];
                send_item(ACT_LOOKUP, key, wv);
            end else begin
                // Mostly absent keys; half are aimed at a random home slot
                key = ($urandom_range(0, 1) == 0) ? $urandom
                                                   : sb.key_homed_at($urandom_range(0, CAPACITY - 1));
                send_item(ACT_LOOKUP, key, wv);
            end
        end
        i_in_valid <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("linear_probe_hash_table_core_tb: PASS");
        end else begin
            $display("linear_probe_hash_table_core_tb: FAIL");
        end
        $finish;
    end

endmodule
